### design/fckvt_pkg.sv
// ----------------------------------------------------------------------------
// Key/value table package
// Request and result types, entry layout and function codes that the key/value
// table modules share.
// ----------------------------------------------------------------------------
package fckvt_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int INDEX_BITS = 4;
	localparam int COUNT_BITS = 5;

	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_UPDATE = 3'd1,
		FN_UPSERT = 3'd2,
		FN_ERASE  = 3'd3,
		FN_GET    = 3'd4,
		FN_GETIDX = 3'd5
	} func_t;

	typedef struct packed {
		func_t                  func;
		logic [KEY_BITS-1:0]    key;
		logic [VALUE_BITS-1:0]  value;
		logic [INDEX_BITS-1:0]  index;
	} req_t;

	typedef struct packed {
		logic                   ok;
		logic [KEY_BITS-1:0]    key_out;
		logic [VALUE_BITS-1:0]  value_out;
		logic [COUNT_BITS-1:0]  count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [VALUE_BITS-1:0]  value;
	} entry_t;

	// Control from the sequencer to the ring of cells.
	typedef struct packed {
		logic   shift;
		entry_t feed;
	} ring_ctl_t;

endpackage

### design/fckvt_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// Holds one key/value entry and, when the ring shifts, takes the entry of its
// neighbor, or the sequencer's feed if it is the tail cell.
// ----------------------------------------------------------------------------
module fckvt_cell (
	input  logic              clk,
	input  logic              shift,
	input  fckvt_pkg::entry_t d,
	output fckvt_pkg::entry_t q
);

	fckvt_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

### design/fckvt_ctrl.sv
// ----------------------------------------------------------------------------
// Table sequencer
// Runs one request per lap of the ring: watches the entry at the head, edits
// the entry it feeds back to the tail, and builds the result.
// ----------------------------------------------------------------------------
module fckvt_ctrl #(
	parameter int CAPACITY = fckvt_pkg::CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  fckvt_pkg::req_t      req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output fckvt_pkg::rsp_t      rsp,
	input  fckvt_pkg::entry_t    head,
	output fckvt_pkg::ring_ctl_t ring
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [CNT_BITS-1:0]  step_q;
	logic [CNT_BITS-1:0]  count_q;
	fckvt_pkg::req_t      req_q;
	fckvt_pkg::entry_t    hold_q;
	fckvt_pkg::entry_t    hold_d;
	fckvt_pkg::entry_t    idx_entry_q;
	logic [fckvt_pkg::VALUE_BITS-1:0] found_val_q;
	logic                 matched_q;
	logic                 rsp_valid_q;
	fckvt_pkg::rsp_t      rsp_q;
	fckvt_pkg::rsp_t      rsp_d;

	logic                 accept;
	logic                 in_range;
	logic                 hit;
	logic                 has_room;
	logic                 last_step;
	logic                 rsp_load;
	logic                 ins_ok;
	logic [CNT_BITS-1:0]  count_d;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign in_range  = (step_q < count_q);
	assign hit       = (state_q == ST_RUN) && in_range && !matched_q && (head.key == req_q.key);
	assign has_room  = (count_q < CNT_BITS'(CAPACITY));
	assign last_step = (step_q == CNT_BITS'(CAPACITY));
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign ins_ok    = !matched_q && has_room;

	// The entry leaving the head passes through the hold_q register, so a lap of
	// CAPACITY+1 shifts brings every entry back to its place. Once an erase has
	// passed its victim, the head bypasses hold_q, which closes the gap.
	always_comb begin
		hold_d = head;
		if (hit && (req_q.func == fckvt_pkg::FN_UPDATE || req_q.func == fckvt_pkg::FN_UPSERT)) begin
			hold_d.value = req_q.value;
		end
		if (!matched_q && (step_q == count_q) && has_room &&
		    (req_q.func == fckvt_pkg::FN_INSERT || req_q.func == fckvt_pkg::FN_UPSERT)) begin
			hold_d.key   = req_q.key;
			hold_d.value = req_q.value;
		end
	end

	assign ring.shift = (state_q == ST_RUN);
	assign ring.feed  = (req_q.func == fckvt_pkg::FN_ERASE && matched_q) ? head : hold_q;

	always_comb begin
		rsp_d   = '0;
		count_d = count_q;
		unique case (req_q.func)
			fckvt_pkg::FN_INSERT: begin
				rsp_d.ok = ins_ok;
				if (ins_ok) begin
					count_d = count_q + CNT_BITS'(1);
				end
			end
			fckvt_pkg::FN_UPDATE: begin
				rsp_d.ok = matched_q;
			end
			fckvt_pkg::FN_UPSERT: begin
				rsp_d.ok = matched_q || ins_ok;
				if (ins_ok) begin
					count_d = count_q + CNT_BITS'(1);
				end
			end
			fckvt_pkg::FN_ERASE: begin
				rsp_d.ok = matched_q;
				if (matched_q) begin
					count_d = count_q - CNT_BITS'(1);
				end
			end
			fckvt_pkg::FN_GET: begin
				rsp_d.ok = matched_q;
				if (matched_q) begin
					rsp_d.value_out = found_val_q;
				end
			end
			fckvt_pkg::FN_GETIDX: begin
				if (32'(req_q.index) < 32'(count_q)) begin
					rsp_d.ok        = 1'b1;
					rsp_d.key_out   = idx_entry_q.key;
					rsp_d.value_out = idx_entry_q.value;
				end
			end
			default: begin
				rsp_d.ok = 1'b0;
			end
		endcase
		rsp_d.count = (fckvt_pkg::COUNT_BITS)'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			matched_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_RUN;
						step_q    <= '0;
						matched_q <= 1'b0;
					end
				end
				ST_RUN: begin
					step_q    <= step_q + CNT_BITS'(1);
					matched_q <= matched_q || hit;
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
						count_q <= count_d;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_RUN) begin
			hold_q <= hold_d;
			if (hit) begin
				found_val_q <= head.value;
			end
			if (32'(step_q) == 32'(req_q.index)) begin
				idx_entry_q <= head;
			end
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_accept_starts_lap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (step_q == '0) && !matched_q)
		else $error("accepted request did not start a lap at step zero");

	a_count_moves_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(rsp_load))
		else $error("entry count changed outside a result load");

	a_result_after_lap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> $past(state_q == ST_RUN) || $past(state_q == ST_DONE))
		else $error("result loaded without a finished lap");
`endif

endmodule

### design/fixed_capacity_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// Fixed-capacity key/value table
// Unsorted array map of unique keys held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// The table keeps up to CAPACITY key/value pairs in insertion order in a ring
// of cells that shift toward the head one place per cycle while a request
// runs. Each request (insert, update, insert-or-update, erase, get by key, get
// by index) takes one full lap of the ring, CAPACITY+1 shifts, during which the
// sequencer compares the entry at the head, edits the entry it feeds back to
// the tail, and closes the gap after an erased entry. A request therefore holds
// off the next one until its lap is done and its result is loaded. The result
// waits in an output register, so the next request is taken while a finished
// result is still stalled. Every request gives exactly one result.
module fixed_capacity_key_value_table_unit #(
	parameter int CAPACITY = fckvt_pkg::CAPACITY
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  fckvt_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fckvt_pkg::rsp_t rsp
);

	fckvt_pkg::entry_t    cell_q [CAPACITY];
	fckvt_pkg::ring_ctl_t ring;

	fckvt_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.head      (cell_q[0]),
		.ring      (ring)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_tail
			fckvt_cell u_cell (
				.clk   (clk),
				.shift (ring.shift),
				.d     (ring.feed),
				.q     (cell_q[i])
			);
		end else begin : g_body
			fckvt_cell u_cell (
				.clk   (clk),
				.shift (ring.shift),
				.d     (cell_q[i+1]),
				.q     (cell_q[i])
			);
		end
	end

endmodule

### dv/tb_fixed_capacity_key_value_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key/value table unit testbench
// Drives requests through the valid/stall request channel and checks every
// result against a behavioral copy of the table that is kept in the bench.
// Directed cases come first, then full-table and back-pressure sequences, then a
// long random mix mostly on a small key pool so lookups hit, and a full table.
// ----------------------------------------------------------------------------
module tb_fixed_capacity_key_value_table_unit;

	localparam int RANDOM_ITEMS   = 1300;
	localparam int KEY_POOL_SIZE  = 20;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int DRAIN_CYCLES   = 2 * (fckvt_pkg::CAPACITY + 3);

	// Function codes that the block does not define.
	localparam logic [2:0] FN_RSVD6 = 3'd6;
	localparam logic [2:0] FN_RSVD7 = 3'd7;

	typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;
	typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_RARE, STALL_HOLD} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	fckvt_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	fckvt_pkg::rsp_t rsp;

	// Behavioral copy of the table, updated at each accepted request.
	logic [fckvt_pkg::KEY_BITS-1:0]   model_keys   [fckvt_pkg::CAPACITY];
	logic [fckvt_pkg::VALUE_BITS-1:0] model_values [fckvt_pkg::CAPACITY];
	int                               model_count = 0;

	fckvt_pkg::rsp_t                  pending_results [$];
	logic [fckvt_pkg::KEY_BITS-1:0]   key_pool [KEY_POOL_SIZE];
	int                               mismatches = 0;
	int                               burst_left = 0;
	int                               hold_off_len = 0;

	fixed_capacity_key_value_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic fckvt_pkg::rsp_t apply_to_model(input fckvt_pkg::req_t r);
		fckvt_pkg::rsp_t res;
		int   pos;
		int   p;
		res = '0;
		pos = -1;
		for (p = 0; p < model_count; p++)
			if (pos < 0 && model_keys[p] == r.key)
				pos = p;
		case (r.func)
			fckvt_pkg::FN_INSERT, fckvt_pkg::FN_UPDATE, fckvt_pkg::FN_UPSERT: begin
				if (pos >= 0) begin
					if (r.func != fckvt_pkg::FN_INSERT) begin
						model_values[pos] = r.value;
						res.ok = 1'b1;
					end
				end else if (r.func != fckvt_pkg::FN_UPDATE &&
				             model_count < fckvt_pkg::CAPACITY) begin
					model_keys[model_count]   = r.key;
					model_values[model_count] = r.value;
					model_count++;
					res.ok = 1'b1;
				end
			end
			fckvt_pkg::FN_ERASE: begin
				if (pos >= 0) begin
					model_count--;
					// Later entries move down one place to close the gap.
					for (p = pos; p < model_count; p++) begin
						model_keys[p]   = model_keys[p + 1];
						model_values[p] = model_values[p + 1];
					end
					res.ok = 1'b1;
				end
			end
			fckvt_pkg::FN_GET: begin
				if (pos >= 0) begin
					res.value_out = model_values[pos];
					res.ok = 1'b1;
				end
			end
			fckvt_pkg::FN_GETIDX: begin
				if (int'(r.index) < model_count) begin
					res.key_out   = model_keys[r.index];
					res.value_out = model_values[r.index];
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
		res.count = (fckvt_pkg::COUNT_BITS)'(model_count);
		return res;
	endfunction

	function automatic fckvt_pkg::req_t make_request(input logic [2:0] func,
			input logic [31:0] key, input logic [31:0] value, input logic [3:0] index);
		fckvt_pkg::req_t r;
		r.func  = fckvt_pkg::func_t'(func);
		r.key   = key;
		r.value = value;
		r.index = index;
		return r;
	endfunction

	function automatic logic [fckvt_pkg::KEY_BITS-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		if (roll < 9 && model_count > 0)
			return model_keys[$urandom_range(0, model_count - 1)];
		return $urandom;
	endfunction

	function automatic fckvt_pkg::req_t random_request(input mix_t mix);
		fckvt_pkg::req_t r;
		int   roll;
		int   bound [6];
		case (mix)
			MIX_FILL:  bound = '{30, 40, 60, 68, 82, 97};
			MIX_DRAIN: bound = '{8, 18, 26, 60, 78, 97};
			default:   bound = '{15, 27, 42, 60, 78, 97};
		endcase
		r.key   = pick_key();
		r.value = $urandom;
		if ($urandom_range(0, 1) == 0 || model_count == 0)
			r.index = 4'($urandom_range(0, 15));
		else
			r.index = 4'($urandom_range(0, model_count - 1));
		roll = $urandom_range(0, 99);
		if (roll < bound[0])      r.func = fckvt_pkg::FN_INSERT;
		else if (roll < bound[1]) r.func = fckvt_pkg::FN_UPDATE;
		else if (roll < bound[2]) r.func = fckvt_pkg::FN_UPSERT;
		else if (roll < bound[3]) r.func = fckvt_pkg::FN_ERASE;
		else if (roll < bound[4]) r.func = fckvt_pkg::FN_GET;
		else if (roll < bound[5]) r.func = fckvt_pkg::FN_GETIDX;
		else r.func = fckvt_pkg::func_t'($urandom_range(0, 1) ? FN_RSVD6 : FN_RSVD7);
		return r;
	endfunction

	task automatic refresh_key_pool();
		int i;
		for (i = 0; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
	endtask

	// Offers one request and returns once it has been transferred. The sender
	// works in bursts; between bursts valid drops for a random gap.
	task automatic send_request(input fckvt_pkg::req_t r);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 30);
			req_valid <= 1'b0;
			req <= random_request(MIX_BALANCED);
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(apply_to_model(r));
	endtask

	task automatic test_directed();
		send_request(make_request(fckvt_pkg::FN_GET, '0, '0, '0));
		send_request(make_request(fckvt_pkg::FN_GETIDX, '0, '0, 4'd0));
		send_request(make_request(fckvt_pkg::FN_UPDATE, 32'd5, 32'd9, '0));
		send_request(make_request(fckvt_pkg::FN_ERASE, 32'd5, '0, '0));
		send_request(make_request(fckvt_pkg::FN_INSERT, '0, '0, '0));
		send_request(make_request(fckvt_pkg::FN_INSERT, '1, '1, '1));
		send_request(make_request(fckvt_pkg::FN_INSERT, '0, 32'h0000_0123, '0));
		send_request(make_request(fckvt_pkg::FN_UPSERT, 32'h8000_0001, 32'h7fff_fffe, '0));
		send_request(make_request(fckvt_pkg::FN_UPSERT, '0, 32'ha5a5_a5a5, '0));
		send_request(make_request(fckvt_pkg::FN_UPDATE, '1, '0, '0));
		send_request(make_request(fckvt_pkg::FN_GET, '0, '1, '0));
		send_request(make_request(fckvt_pkg::FN_GET, '1, '0, '0));
		send_request(make_request(fckvt_pkg::FN_GET, 32'h0001_2345, '0, '0));
		send_request(make_request(fckvt_pkg::FN_GETIDX, '0, '0, 4'd2));
		send_request(make_request(fckvt_pkg::FN_GETIDX, '0, '0, 4'd3));
		send_request(make_request(fckvt_pkg::FN_GETIDX, '1, '1, 4'd15));
		send_request(make_request(fckvt_pkg::FN_ERASE, '0, '0, '0));
		send_request(make_request(fckvt_pkg::FN_GETIDX, '0, '0, 4'd0));
		send_request(make_request(FN_RSVD6, '1, '1, '1));
		send_request(make_request(FN_RSVD7, 32'h8000_0001, 32'h5a5a_5a5a, 4'd1));
		send_request(make_request(fckvt_pkg::FN_ERASE, '1, '0, '0));
		send_request(make_request(fckvt_pkg::FN_GET, 32'h8000_0001, '0, '0));
		send_request(make_request(fckvt_pkg::FN_ERASE, 32'h8000_0001, '0, '0));
	endtask

	// Fills the table to capacity, exercises every request on a full table,
	// then drains it in random order.
	task automatic test_full_table();
		while (model_count < fckvt_pkg::CAPACITY)
			send_request(make_request(
				$urandom_range(0, 1) ? fckvt_pkg::FN_INSERT : fckvt_pkg::FN_UPSERT,
				$urandom, $urandom, '0));
		send_request(make_request(fckvt_pkg::FN_INSERT, $urandom, $urandom, '0));
		send_request(make_request(fckvt_pkg::FN_UPSERT, $urandom, $urandom, '0));
		send_request(make_request(fckvt_pkg::FN_UPSERT, model_keys[3], $urandom, '0));
		send_request(make_request(fckvt_pkg::FN_UPDATE,
			model_keys[fckvt_pkg::CAPACITY - 1], $urandom, '0));
		send_request(make_request(fckvt_pkg::FN_INSERT, model_keys[0], $urandom, '0));
		send_request(make_request(fckvt_pkg::FN_GETIDX, '0, '0, 4'd15));
		send_request(make_request(fckvt_pkg::FN_GET,
			model_keys[fckvt_pkg::CAPACITY - 1], '0, '0));
		while (model_count > 0) begin
			send_request(make_request(fckvt_pkg::FN_ERASE,
				model_keys[$urandom_range(0, model_count - 1)], '0, '0));
			if ($urandom_range(0, 3) == 0)
				send_request(make_request(fckvt_pkg::FN_GETIDX, '0, '0,
					4'($urandom_range(0, 15))));
		end
		send_request(make_request(fckvt_pkg::FN_ERASE, $urandom, '0, '0));
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering back to back, so the result register and the input both stall.
	task automatic test_backpressure();
		refresh_key_pool();
		hold_off_len = HOLD_OFF_LEN;
		burst_left = 100;
		repeat (12)
			send_request(random_request(MIX_FILL));
	endtask

	task automatic test_random_mix(input int total);
		int   sent;
		int   phase_len;
		mix_t mix;
		sent = 0;
		while (sent < total) begin
			refresh_key_pool();
			mix = mix_t'($urandom_range(0, 2));
			phase_len = $urandom_range(40, 160);
			while (phase_len > 0 && sent < total) begin
				send_request(random_request(mix));
				phase_len--;
				sent++;
			end
		end
	endtask

	// Receiver stall pattern: stretches of random length, each with its own
	// stall density, including stretches with no stall at all.
	initial begin : receiver
		int          stretch;
		stall_mode_t mode;
		rsp_stall = 1'b0;
		forever begin
			if (hold_off_len != 0) begin
				stretch = hold_off_len;
				hold_off_len = 0;
				mode = STALL_HOLD;
			end else begin
				stretch = $urandom_range(8, 60);
				mode = stall_mode_t'($urandom_range(0, 3));
			end
			while (stretch > 0 && (mode == STALL_HOLD || hold_off_len == 0)) begin
				@(negedge clk);
				case (mode)
					STALL_NONE:  rsp_stall <= 1'b0;
					STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
					STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
					STALL_RARE:  rsp_stall <= ($urandom_range(0, 9) == 0);
					default:     rsp_stall <= 1'b1;
				endcase
				stretch--;
			end
		end
	end

	task automatic report_field(input string field_name, input logic [31:0] expected_v,
			input logic [31:0] actual_v);
		if (actual_v !== expected_v) begin
			$display("%0t ns: %s expected %h got %h", $time, field_name, expected_v, actual_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		fckvt_pkg::rsp_t expected_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result transfer expected none got %p", $time, rsp);
				mismatches++;
			end else begin
				expected_rsp = pending_results.pop_front();
				report_field("ok", 32'(expected_rsp.ok), 32'(rsp.ok));
				report_field("key_out", expected_rsp.key_out, rsp.key_out);
				report_field("value_out", expected_rsp.value_out, rsp.value_out);
				report_field("count", 32'(expected_rsp.count), 32'(rsp.count));
			end
		end
	end

	// Ends the run when no transfer on either channel happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		refresh_key_pool();
		test_directed();
		test_full_table();
		test_backpressure();
		test_random_mix(RANDOM_ITEMS);
		test_full_table();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### fixed_capacity_key_value_table_unit.f
design/fckvt_pkg.sv
design/fckvt_cell.sv
design/fckvt_ctrl.sv
design/fixed_capacity_key_value_table_unit.sv
dv/tb_fixed_capacity_key_value_table_unit.sv
